### sv/plst_pkg.sv
package plst_pkg;

  // Default number of cells in the store
  localparam int unsigned PLST_CAPACITY = 16;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 5;

  // Request codes
  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
  localparam logic [OP_W-1:0] OP_BADOP  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADOP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  // Per-cell update control
  typedef struct packed {
    logic load_new;   // take the inserted value
    logic shift_up;   // take the left neighbour's value
    logic shift_dn;   // take the right neighbour's value
  } cell_ctrl_t;

endpackage

### sv/plst_if.sv
interface plst_req_if;
  import plst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] new_value;

  modport source (output valid, op, position, new_value, input ready);
  modport sink   (input valid, op, position, new_value, output ready);
endinterface

interface plst_rsp_if;
  import plst_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] value_out;
  logic [LEN_W-1:0]         length;

  modport source (output valid, status, value_out, length, input ready);
  modport sink   (input valid, status, value_out, length, output ready);
endinterface

### sv/plst_cell.sv
module plst_cell
  import plst_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] new_value_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] value_o
);

  logic signed [DATA_W-1:0] value_d, value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load_new) begin
      value_d = new_value_i;
    end else if (ctrl_i.shift_up) begin
      value_d = left_i;
    end else if (ctrl_i.shift_dn) begin
      value_d = right_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

### sv/positional_list_store_top.sv
// Channel  Dir  Payload                              Handshake
// in_i     in   op[1:0] position[7:0] new_value[31:0] valid/ready
// out_o    out  status[2:0] value_out[31:0] length[4:0] valid/ready
//
// One item per cycle; each result is registered in the output register in the
// cycle after its item is taken. Every cell moves in parallel, so all cells
// take the shift for insert or delete together, at the same clock edge.
// A new item is taken while the held result is taken in the same cycle.
// Stall on out_o stops intake once the output register is full.
// rst_ni clears the entry count and the output valid; cell contents are
// left as they are and are never read before being written.
module positional_list_store_top
  import plst_pkg::*;
#(
  parameter int unsigned CAPACITY = PLST_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plst_req_if.sink  in_i,
  plst_rsp_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CMP_W = POS_W + 1;

  // Row of cells
  cell_ctrl_t               cell_ctrl [CAPACITY];
  logic signed [DATA_W-1:0] cell_val  [CAPACITY];

  logic [CNT_W-1:0]    count_d, count_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_d, status_q;
  logic signed [DATA_W-1:0] value_d, value_q;
  logic [LEN_W-1:0]    length_q;

  logic             accept;
  logic [POS_W-1:0] idx;
  logic [CMP_W-1:0] idx_w, count_w;
  logic             do_insert, do_delete;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // 1-based position, zero and one both pick the head
  assign idx     = (in_i.position <= POS_W'(1)) ? '0 : in_i.position - POS_W'(1);
  assign idx_w   = CMP_W'(idx);
  assign count_w = CMP_W'(count_q);

  // Checks in priority order: empty, past the end, bad op, full
  always_comb begin
    status_d  = ST_OK;
    value_d   = '0;
    count_d   = count_q;
    do_insert = 1'b0;
    do_delete = 1'b0;
    if (count_q == '0 && !(in_i.op == OP_INSERT && idx == '0)) begin
      status_d = ST_EMPTY;
    end else if (count_q != '0 && idx_w >= count_w) begin
      status_d = ST_RANGE;
    end else begin
      unique case (in_i.op)
        OP_ACCESS: begin
          value_d = cell_val[idx[IDX_W-1:0]];
        end
        OP_DELETE: begin
          do_delete = 1'b1;
          count_d   = count_q - CNT_W'(1);
        end
        OP_INSERT: begin
          if (count_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            do_insert = 1'b1;
            count_d   = count_q + CNT_W'(1);
            value_d   = in_i.new_value;
          end
        end
        default: begin
          status_d = ST_BADOP;
        end
      endcase
    end
  end

  // Cell i moves up past the insert point, down from the delete point
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CI = CMP_W'(i);

    always_comb begin
      cell_ctrl[i].load_new = accept && do_insert && (CI == idx_w);
      cell_ctrl[i].shift_up = accept && do_insert && (CI > idx_w);
      cell_ctrl[i].shift_dn = accept && do_delete && (CI >= idx_w)
                              && (CI + CMP_W'(1) < count_w);
    end

    plst_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .new_value_i (in_i.new_value),
      .left_i      ((i == 0) ? in_i.new_value : cell_val[(i == 0) ? 0 : i - 1]),
      .right_i     ((i == CAPACITY - 1) ? cell_val[i]
                                        : cell_val[(i == CAPACITY - 1) ? i : i + 1]),
      .value_o     (cell_val[i])
    );
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= value_d;
      length_q <= LEN_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.value_out = value_q;
  assign out_o.length    = length_q;

endmodule

### sv/plst_chk.sv
module plst_chk
  import plst_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [DATA_W-1:0]   value_i,
  input logic [LEN_W-1:0]    length_i
);

  // Held result stays while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Every taken item has a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result after taken item");

  // Errors carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> value_i == '0)
    else $error("non-zero value on error");

  // Empty status only with an empty list
  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_EMPTY |-> length_i == '0)
    else $error("empty status with entries held");

endmodule

bind positional_list_store_top plst_chk u_plst_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .value_i     (out_o.value_out),
  .length_i    (out_o.length)
);
